[src/laser_line_row_peak_detector_assert.svh]
// Assertion macros for the checker file of the row peak detector.
`ifndef LASER_LINE_ROW_PEAK_DETECTOR_ASSERT_SVH
`define LASER_LINE_ROW_PEAK_DETECTOR_ASSERT_SVH

// Checked at every rising clock edge while reset is low.
`define LLRPD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define LLRPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/llrpd_pkg.sv]
package llrpd_pkg;

   localparam int MAX_COLS_DEF = 2048;
   localparam int MAX_ROWS_DEF = 2048;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_QUAD_A       = 3'd2,
      CSR_QUAD_B       = 3'd3,
      CSR_QUAD_C       = 3'd4,
      CSR_QUAD_D       = 3'd5
   } csr_index_type;

   localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
   localparam logic [23:0] QUAD_A_RST       = 24'd0;
   localparam logic [23:0] QUAD_B_RST       = 24'd479;
   localparam logic [23:0] QUAD_C_RST       = 24'd2617823;
   localparam logic [23:0] QUAD_D_RST       = 24'd2617344;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   typedef enum logic {
      KIND_PIXEL   = 1'b0,
      KIND_READOUT = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        frame_start;
      logic [7:0]  score;
      logic [23:0] color;
      logic [10:0] query_row;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic [11:0] frame_width;
      logic [11:0] frame_height;
      logic [23:0] quad_a;
      logic [23:0] quad_b;
      logic [23:0] quad_c;
      logic [23:0] quad_d;
   } cfg_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_READ,
      B_MUL,
      B_EVAL,
      B_RESP
   } back_state_type;

endpackage

[src/llrpd_front.sv]
module llrpd_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic              req_frame_start,
   input  logic [7:0]        req_on_red,
   input  logic [7:0]        req_on_green,
   input  logic [7:0]        req_on_blue,
   input  logic [7:0]        req_off_red,
   input  logic [7:0]        req_off_green,
   input  logic [7:0]        req_off_blue,
   input  logic [10:0]       req_query_row,
   input  logic              queue_full,
   output logic              push,
   output llrpd_pkg::item_type item
);

   logic [7:0] diff_r, diff_g, diff_b, half;
   logic [8:0] gb_sum;

   always_comb begin
      diff_r = (req_on_red   > req_off_red)   ? req_on_red   - req_off_red   : 8'd0;
      diff_g = (req_on_green > req_off_green) ? req_on_green - req_off_green : 8'd0;
      diff_b = (req_on_blue  > req_off_blue)  ? req_on_blue  - req_off_blue  : 8'd0;
      gb_sum = {1'b0, diff_g} + {1'b0, diff_b};
      half   = gb_sum[8:1];
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      item.kind        = req_type ? llrpd_pkg::KIND_READOUT : llrpd_pkg::KIND_PIXEL;
      item.frame_start = req_frame_start;
      item.score       = (diff_r > half) ? diff_r - half : 8'd0;
      item.color       = {req_off_red, req_off_green, req_off_blue};
      item.query_row   = req_query_row;
   end

endmodule

[src/llrpd_queue.sv]
module llrpd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  llrpd_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output llrpd_pkg::head_type head
);

   localparam int CNT_W = llrpd_pkg::QUEUE_PTR_W + 1;

   llrpd_pkg::item_type                  entry_ff [llrpd_pkg::QUEUE_DEPTH];
   logic [llrpd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                     count_ff, count_in;
   logic                                 do_push, do_pop;

   assign full       = (count_ff == CNT_W'(llrpd_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[src/llrpd_back.sv]
module llrpd_back #(
   parameter int MAX_COLS = llrpd_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = llrpd_pkg::MAX_ROWS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  llrpd_pkg::cfg_type  cfg,
   input  llrpd_pkg::head_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_point_found,
   output logic [10:0]         rsp_point_column,
   output logic [10:0]         rsp_point_row,
   output logic [7:0]          rsp_color_red,
   output logic [7:0]          rsp_color_green,
   output logic [7:0]          rsp_color_blue
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int ENT_W = 8 + COL_W + 24;

   llrpd_pkg::back_state_type state_ff, state_in;

   logic [ENT_W-1:0] mem [MAX_ROWS];
   logic [ENT_W-1:0] rd_data_ff;
   logic             wr_en, rd_en;
   logic [ROW_W-1:0] wr_addr, rd_addr;
   logic [ENT_W-1:0] wr_data;

   logic [11:0]      cc_ff, cc_in, rc_ff, rc_in;
   logic [7:0]       rp_ff, rp_in;
   logic [COL_W-1:0] rcol_ff, rcol_in;
   logic [23:0]      rcolor_ff, rcolor_in;
   logic [18:0]      psum_ff, psum_in;

   logic [10:0]      q_ff, q_in;
   logic             in_range_ff, in_range_in, ok_ff, ok_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [23:0]      color_ff, color_in;
   logic [1:0]       edge_ff, edge_in;
   logic signed [25:0] p1_ff, p1_in, p2_ff, p2_in;
   logic             inside_ff, inside_in, on_ff, on_in;

   logic             found_ff, found_in;
   logic [10:0]      out_col_ff, out_col_in;
   logic [23:0]      out_color_ff, out_color_in;

   logic [11:0] eff_w, eff_h;
   logic [11:0] cc, rc;
   logic [7:0]  rp, np;
   logic [COL_W-1:0] ncol;
   logic [23:0] rcolor, ncolor;
   logic [18:0] psum;
   logic        upd;
   logic [12:0] cc_next;
   logic [11:0] q12;
   logic [7:0]  rd_peak;
   logic [COL_W-1:0] rd_col;
   logic [23:0] rd_color;
   logic [20:0] thr;
   logic [23:0] vi, vj;
   logic [11:0] xi, yi, xj, yj, px, py;
   logic signed [12:0] dxe, dye, dxp, dyp;
   logic        on_edge, crosses, left, inside_n, on_n;

   always_comb begin
      eff_w = cfg.frame_width;
      if (cfg.frame_width == '0) begin
         eff_w = 12'd1;
      end else if ({1'b0, cfg.frame_width} > 13'(MAX_COLS)) begin
         eff_w = 12'(MAX_COLS);
      end
      eff_h = cfg.frame_height;
      if (cfg.frame_height == '0) begin
         eff_h = 12'd1;
      end else if ({1'b0, cfg.frame_height} > 13'(MAX_ROWS)) begin
         eff_h = 12'(MAX_ROWS);
      end
   end

   // Quad edge geometry for the edge being worked on.
   always_comb begin
      case (edge_ff)
         2'd0: begin
            vi = cfg.quad_a;
            vj = cfg.quad_b;
         end
         2'd1: begin
            vi = cfg.quad_b;
            vj = cfg.quad_c;
         end
         2'd2: begin
            vi = cfg.quad_c;
            vj = cfg.quad_d;
         end
         default: begin
            vi = cfg.quad_d;
            vj = cfg.quad_a;
         end
      endcase
      xi  = vi[23:12];
      yi  = vi[11:0];
      xj  = vj[23:12];
      yj  = vj[11:0];
      px  = 12'(col_ff);
      py  = {1'b0, q_ff};
      dxe = $signed({1'b0, xj}) - $signed({1'b0, xi});
      dye = $signed({1'b0, yj}) - $signed({1'b0, yi});
      dxp = $signed({1'b0, px}) - $signed({1'b0, xi});
      dyp = $signed({1'b0, py}) - $signed({1'b0, yi});
      p1_in = dxe * dyp;
      p2_in = dye * dxp;
      on_edge = (p1_ff == p2_ff)
         && (px >= ((xi < xj) ? xi : xj)) && (px <= ((xi < xj) ? xj : xi))
         && (py >= ((yi < yj) ? yi : yj)) && (py <= ((yi < yj) ? yj : yi));
      crosses  = (yi > py) != (yj > py);
      left     = (dye > 0) ? (p2_ff < p1_ff) : (p2_ff > p1_ff);
      inside_n = inside_ff ^ (crosses && left);
      on_n     = on_ff || on_edge;
   end

   always_comb begin
      {rd_peak, rd_col, rd_color} = rd_data_ff;
      thr = 21'({rd_peak, 1'b1}) * 21'(eff_h);
      q12 = {1'b0, head.item.query_row};

      cc     = head.item.frame_start ? '0 : cc_ff;
      rc     = head.item.frame_start ? '0 : rc_ff;
      rp     = head.item.frame_start ? '0 : rp_ff;
      rcolor = head.item.frame_start ? '0 : rcolor_ff;
      psum   = head.item.frame_start ? '0 : psum_ff;
      upd    = head.item.score > rp;
      np     = upd ? head.item.score : rp;
      ncol   = upd ? cc[COL_W-1:0] : (head.item.frame_start ? '0 : rcol_ff);
      ncolor = upd ? head.item.color : rcolor;
      cc_next = {1'b0, cc} + 13'd1;

      state_in     = state_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = rc[ROW_W-1:0];
      wr_data      = {np, ncol, ncolor};
      rd_en        = 1'b0;
      rd_addr      = q12[ROW_W-1:0];
      cc_in        = cc_ff;
      rc_in        = rc_ff;
      rp_in        = rp_ff;
      rcol_in      = rcol_ff;
      rcolor_in    = rcolor_ff;
      psum_in      = psum_ff;
      q_in         = q_ff;
      in_range_in  = in_range_ff;
      ok_in        = ok_ff;
      col_in       = col_ff;
      color_in     = color_ff;
      edge_in      = edge_ff;
      inside_in    = inside_ff;
      on_in        = on_ff;
      found_in     = found_ff;
      out_col_in   = out_col_ff;
      out_color_in = out_color_ff;

      case (state_ff)
         llrpd_pkg::B_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.item.kind == llrpd_pkg::KIND_READOUT) begin
                  rd_en       = 1'b1;
                  q_in        = head.item.query_row;
                  in_range_in = q12 < eff_h;
                  state_in    = llrpd_pkg::B_READ;
               end else begin
                  cc_in     = cc;
                  rc_in     = rc;
                  rp_in     = rp;
                  rcol_in   = head.item.frame_start ? '0 : rcol_ff;
                  rcolor_in = rcolor;
                  psum_in   = psum;
                  if (rc < eff_h) begin
                     if (cc_next >= {1'b0, eff_w}) begin
                        wr_en     = 1'b1;
                        psum_in   = psum + 19'(np);
                        rc_in     = rc + 12'd1;
                        cc_in     = '0;
                        rp_in     = '0;
                        rcol_in   = '0;
                        rcolor_in = '0;
                     end else begin
                        cc_in     = cc_next[11:0];
                        rp_in     = np;
                        rcol_in   = ncol;
                        rcolor_in = ncolor;
                     end
                  end
               end
            end
         end
         llrpd_pkg::B_READ: begin
            ok_in     = in_range_ff && (rd_peak != '0) && (21'(psum_ff) < thr);
            col_in    = rd_col;
            color_in  = rd_color;
            edge_in   = '0;
            inside_in = 1'b0;
            on_in     = 1'b0;
            state_in  = llrpd_pkg::B_MUL;
         end
         llrpd_pkg::B_MUL: begin
            state_in = llrpd_pkg::B_EVAL;
         end
         llrpd_pkg::B_EVAL: begin
            inside_in = inside_n;
            on_in     = on_n;
            if (edge_ff == 2'd3) begin
               found_in     = ok_ff && (inside_n || on_n);
               out_col_in   = found_in ? 11'(col_ff) : '0;
               out_color_in = found_in ? color_ff : '0;
               state_in     = llrpd_pkg::B_RESP;
            end else begin
               edge_in  = edge_ff + 2'd1;
               state_in = llrpd_pkg::B_MUL;
            end
         end
         llrpd_pkg::B_RESP: begin
            if (rsp_ready) begin
               state_in = llrpd_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = llrpd_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= llrpd_pkg::B_IDLE;
         cc_ff     <= '0;
         rc_ff     <= '0;
         rp_ff     <= '0;
         rcol_ff   <= '0;
         rcolor_ff <= '0;
         psum_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         cc_ff     <= cc_in;
         rc_ff     <= rc_in;
         rp_ff     <= rp_in;
         rcol_ff   <= rcol_in;
         rcolor_ff <= rcolor_in;
         psum_ff   <= psum_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff         <= q_in;
      in_range_ff  <= in_range_in;
      ok_ff        <= ok_in;
      col_ff       <= col_in;
      color_ff     <= color_in;
      edge_ff      <= edge_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      inside_ff    <= inside_in;
      on_ff        <= on_in;
      found_ff     <= found_in;
      out_col_ff   <= out_col_in;
      out_color_ff <= out_color_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid        = (state_ff == llrpd_pkg::B_RESP);
   assign rsp_point_found  = found_ff;
   assign rsp_point_column = out_col_ff;
   assign rsp_point_row    = q_ff;
   assign rsp_color_red    = out_color_ff[23:16];
   assign rsp_color_green  = out_color_ff[15:8];
   assign rsp_color_blue   = out_color_ff[7:0];

endmodule

[src/laser_line_row_peak_detector.sv]
// Channel   Handshake                    Contents
// req       req_valid / req_ready        one pixel pair or one row readout
// rsp       rsp_valid / rsp_ready        one readout result
// csr       csr_write_enable             register write, index and data
//
// A pixel pair is taken while the back end is idle, so pixels stream at one per
// clock while no readout holds the back end. A readout keeps the back end busy
// until rsp_valid rises: the pop with its store read, the peak and threshold
// check, then a multiply step and an evaluate step for each of the four quad
// edges on the shared pair of multipliers. The result then holds until rsp_ready.
// Reset is synchronous and active high; the row store is not cleared by it.
// The four-entry queue keeps taking pixels while a readout result waits, until full.
module laser_line_row_peak_detector #(
   parameter int MAX_COLS = llrpd_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = llrpd_pkg::MAX_ROWS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic                             req_frame_start,
   input  logic [7:0]                       req_on_red,
   input  logic [7:0]                       req_on_green,
   input  logic [7:0]                       req_on_blue,
   input  logic [7:0]                       req_off_red,
   input  logic [7:0]                       req_off_green,
   input  logic [7:0]                       req_off_blue,
   input  logic [10:0]                      req_query_row,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_point_found,
   output logic [10:0]                      rsp_point_column,
   output logic [10:0]                      rsp_point_row,
   output logic [7:0]                       rsp_color_red,
   output logic [7:0]                       rsp_color_green,
   output logic [7:0]                       rsp_color_blue,
   input  logic                             csr_write_enable,
   input  logic [llrpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [llrpd_pkg::CSR_DATA_W-1:0] csr_write_data
);

   // Configuration registers. Writes to unused indexes are dropped.
   llrpd_pkg::cfg_type  cfg_ff, cfg_in;
   llrpd_pkg::item_type item;
   llrpd_pkg::head_type head;
   logic                push, full, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            llrpd_pkg::CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_write_data[11:0];
            llrpd_pkg::CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_write_data[11:0];
            llrpd_pkg::CSR_QUAD_A:       cfg_in.quad_a       = csr_write_data;
            llrpd_pkg::CSR_QUAD_B:       cfg_in.quad_b       = csr_write_data;
            llrpd_pkg::CSR_QUAD_C:       cfg_in.quad_c       = csr_write_data;
            llrpd_pkg::CSR_QUAD_D:       cfg_in.quad_d       = csr_write_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= llrpd_pkg::FRAME_WIDTH_RST;
         cfg_ff.frame_height <= llrpd_pkg::FRAME_HEIGHT_RST;
         cfg_ff.quad_a       <= llrpd_pkg::QUAD_A_RST;
         cfg_ff.quad_b       <= llrpd_pkg::QUAD_B_RST;
         cfg_ff.quad_c       <= llrpd_pkg::QUAD_C_RST;
         cfg_ff.quad_d       <= llrpd_pkg::QUAD_D_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end scores each pixel pair as it is transferred in.
   llrpd_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_frame_start (req_frame_start),
      .req_on_red      (req_on_red),
      .req_on_green    (req_on_green),
      .req_on_blue     (req_on_blue),
      .req_off_red     (req_off_red),
      .req_off_green   (req_off_green),
      .req_off_blue    (req_off_blue),
      .req_query_row   (req_query_row),
      .queue_full      (full),
      .push            (push),
      .item            (item)
   );

   llrpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (item),
      .full      (full),
      .pop       (pop),
      .head      (head)
   );

   // The back end tracks row peaks, owns the row store and answers readouts.
   llrpd_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_point_found  (rsp_point_found),
      .rsp_point_column (rsp_point_column),
      .rsp_point_row    (rsp_point_row),
      .rsp_color_red    (rsp_color_red),
      .rsp_color_green  (rsp_color_green),
      .rsp_color_blue   (rsp_color_blue)
   );

endmodule

[src/llrpd_checker.sv]
`include "laser_line_row_peak_detector_assert.svh"

module llrpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_point_found,
   input logic [10:0] rsp_point_column,
   input logic [10:0] rsp_point_row,
   input logic [7:0]  rsp_color_red,
   input logic [7:0]  rsp_color_green,
   input logic [7:0]  rsp_color_blue
);

   `LLRPD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_found) && $stable(rsp_point_row) && $stable(rsp_point_column), "result changed while stalled")
   `LLRPD_ASSERT(a_not_found_zero, clock, reset, rsp_valid && !rsp_point_found |-> rsp_point_column == 11'd0 && rsp_color_red == 8'd0 && rsp_color_green == 8'd0 && rsp_color_blue == 8'd0, "not found result carries data")
   `LLRPD_ASSERT(a_gap_after_transfer, clock, reset, rsp_valid && rsp_ready |=> !rsp_valid, "results transferred back to back")
   `LLRPD_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind laser_line_row_peak_detector llrpd_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_point_found  (rsp_point_found),
   .rsp_point_column (rsp_point_column),
   .rsp_point_row    (rsp_point_row),
   .rsp_color_red    (rsp_color_red),
   .rsp_color_green  (rsp_color_green),
   .rsp_color_blue   (rsp_color_blue)
);

[sim/laser_line_row_peak_detector_checker.sv]
module laser_line_row_peak_detector_checker
   import llrpd_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_type,
   input  logic                  req_frame_start,
   input  logic [7:0]            req_on_red,
   input  logic [7:0]            req_on_green,
   input  logic [7:0]            req_on_blue,
   input  logic [7:0]            req_off_red,
   input  logic [7:0]            req_off_green,
   input  logic [7:0]            req_off_blue,
   input  logic [10:0]           req_query_row,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_point_found,
   input  logic [10:0]           rsp_point_column,
   input  logic [10:0]           rsp_point_row,
   input  logic [7:0]            rsp_color_red,
   input  logic [7:0]            rsp_color_green,
   input  logic [7:0]            rsp_color_blue,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    error_count,
   output int                    pending_count
);

   typedef struct packed {
      logic        found;
      logic [10:0] column;
      logic [10:0] row;
      logic [23:0] color;
   } point_type;

   cfg_type     cfg;
   logic [7:0]  peak_mem   [MAX_ROWS];
   logic [10:0] column_mem [MAX_ROWS];
   logic [23:0] color_mem  [MAX_ROWS];
   logic [18:0] sum_of_peaks;
   int          col_pos, row_pos;
   logic [7:0]  best_score;
   logic [10:0] best_column;
   logic [23:0] best_color;
   point_type   expected_points[$];

   function automatic int clamp_size(logic [11:0] v, int max_v);
      if (v == 0) return 1;
      if (v > max_v) return max_v;
      return v;
   endfunction

   function automatic logic [7:0] byte_gain(logic [7:0] on_v, logic [7:0] off_v);
      return (on_v > off_v) ? on_v - off_v : 8'd0;
   endfunction

   // Crossing-number test; points on an edge or corner are inside.
   function automatic logic point_in_quad(longint px, longint py);
      logic [23:0] corner[4];
      longint xs[4], ys[4];
      longint xi, yi, xj, yj, cross_prod, dy, lhs, rhs;
      logic in_poly, left;
      int j;
      corner = '{cfg.quad_a, cfg.quad_b, cfg.quad_c, cfg.quad_d};
      in_poly = 1'b0;
      for (int i = 0; i < 4; i++) begin
         xs[i] = corner[i][23:12];
         ys[i] = corner[i][11:0];
      end
      for (int i = 0; i < 4; i++) begin
         j = (i + 1) % 4;
         xi = xs[i]; yi = ys[i]; xj = xs[j]; yj = ys[j];
         cross_prod = (xj - xi) * (py - yi) - (yj - yi) * (px - xi);
         if (cross_prod == 0 && px >= (xi < xj ? xi : xj) && px <= (xi < xj ? xj : xi) &&
             py >= (yi < yj ? yi : yj) && py <= (yi < yj ? yj : yi))
            return 1'b1;
         if ((yi > py) != (yj > py)) begin
            dy = yj - yi;
            lhs = (px - xi) * dy;
            rhs = (py - yi) * (xj - xi);
            left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
            if (left) in_poly = !in_poly;
         end
      end
      return in_poly;
   endfunction

   task automatic accumulate_pixel();
      logic [7:0] dr, dg, db, half, score;
      int width, height;
      width  = clamp_size(cfg.frame_width, MAX_COLS);
      height = clamp_size(cfg.frame_height, MAX_ROWS);
      if (req_frame_start) begin
         sum_of_peaks = '0; col_pos = 0; row_pos = 0;
         best_score = '0; best_column = '0; best_color = '0;
      end
      if (row_pos >= height) return;
      dr = byte_gain(req_on_red, req_off_red);
      dg = byte_gain(req_on_green, req_off_green);
      db = byte_gain(req_on_blue, req_off_blue);
      half = 8'(({1'b0, dg} + {1'b0, db}) >> 1);
      score = (dr > half) ? dr - half : 8'd0;
      if (score > best_score) begin
         best_score = score;
         best_column = 11'(col_pos);
         best_color = {req_off_red, req_off_green, req_off_blue};
      end
      col_pos++;
      if (col_pos >= width) begin
         peak_mem[row_pos] = best_score;
         column_mem[row_pos] = best_column;
         color_mem[row_pos] = best_color;
         sum_of_peaks = sum_of_peaks + 19'(best_score);
         row_pos++;
         col_pos = 0;
         best_score = '0; best_column = '0; best_color = '0;
      end
   endtask

   function automatic point_type predict_readout(logic [10:0] q);
      point_type p;
      int height, average;
      height = clamp_size(cfg.frame_height, MAX_ROWS);
      p = '0;
      p.row = q;
      if (q < height) begin
         average = sum_of_peaks / height;
         if (peak_mem[q] > 0 && 2 * int'(peak_mem[q]) >= average &&
             point_in_quad(column_mem[q], q)) begin
            p.found = 1'b1;
            p.column = column_mem[q];
            p.color = color_mem[q];
         end
      end
      return p;
   endfunction

   always @(posedge clock) begin
      point_type want;
      int errs;
      errs = 0;
      if (reset) begin
         cfg <= '{FRAME_WIDTH_RST, FRAME_HEIGHT_RST, QUAD_A_RST, QUAD_B_RST,
                  QUAD_C_RST, QUAD_D_RST};
         sum_of_peaks = '0; col_pos = 0; row_pos = 0;
         best_score = '0; best_column = '0; best_color = '0;
         expected_points.delete();
         error_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("result transfer with no readout outstanding");
               errs++;
            end else begin
               want = expected_points.pop_front();
               if (want.found !== rsp_point_found) begin
                  $error("point_found exp %0d got %0d", want.found, rsp_point_found);
                  errs++;
               end
               if (want.column !== rsp_point_column) begin
                  $error("point_column exp %0d got %0d", want.column, rsp_point_column);
                  errs++;
               end
               if (want.row !== rsp_point_row) begin
                  $error("point_row exp %0d got %0d", want.row, rsp_point_row);
                  errs++;
               end
               if (want.color[23:16] !== rsp_color_red) begin
                  $error("color_red exp %0d got %0d", want.color[23:16], rsp_color_red);
                  errs++;
               end
               if (want.color[15:8] !== rsp_color_green) begin
                  $error("color_green exp %0d got %0d", want.color[15:8], rsp_color_green);
                  errs++;
               end
               if (want.color[7:0] !== rsp_color_blue) begin
                  $error("color_blue exp %0d got %0d", want.color[7:0], rsp_color_blue);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_type == KIND_READOUT)
               expected_points.insert(expected_points.size(),
                                      predict_readout(req_query_row));
            else
               accumulate_pixel();
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  cfg.frame_width  <= csr_write_data[11:0];
               CSR_FRAME_HEIGHT: cfg.frame_height <= csr_write_data[11:0];
               CSR_QUAD_A:       cfg.quad_a <= csr_write_data;
               CSR_QUAD_B:       cfg.quad_b <= csr_write_data;
               CSR_QUAD_C:       cfg.quad_c <= csr_write_data;
               CSR_QUAD_D:       cfg.quad_d <= csr_write_data;
               default: ;
            endcase
         end
         error_count <= error_count + errs;
      end
      pending_count <= expected_points.size();
   end

endmodule

[sim/tb_laser_line_row_peak_detector.sv]
module tb_laser_line_row_peak_detector;
   import llrpd_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = 1'b0;
   logic                  req_frame_start = 1'b0;
   logic [7:0]            req_on_red = '0, req_on_green = '0, req_on_blue = '0;
   logic [7:0]            req_off_red = '0, req_off_green = '0, req_off_blue = '0;
   logic [10:0]           req_query_row = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_point_found;
   logic [10:0]           rsp_point_column, rsp_point_row;
   logic [7:0]            rsp_color_red, rsp_color_green, rsp_color_blue;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   int                    error_count, pending_count;

   // Receiver control: a quiet stretch with no stalls and one long hold-off.
   logic                  sink_steady = 1'b0;
   logic                  sink_hold = 1'b0;
   logic                  source_steady = 1'b0;
   // Number of rows of the current frame that have been completed, so
   // readouts never touch a row whose store entry was never written.
   int                    rows_written = 0;
   int                    frame_w = 640, frame_h = 480;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   laser_line_row_peak_detector u_dut (.*);

   laser_line_row_peak_detector_checker u_checker (.*);

   initial begin
      #200_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // The result side stalls about 19 percent of the time, except during the
   // quiet stretch and during the deliberate long hold-off.
   initial begin
      forever begin
         @(negedge clock);
         if (sink_hold) rsp_ready <= 1'b0;
         else if (sink_steady) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(99) >= 19);
      end
   end

   // Hold the result side off while readouts keep coming, so that the input
   // queue fills and the input stalls.
   task automatic long_hold_off();
      sink_hold = 1'b1;
      for (int i = 0; i < 300; i++) @(negedge clock);
      sink_hold = 1'b0;
   endtask

   // One transfer on the request channel; valid stays up between back-to-back
   // items, only dropping for random idle spells when the source is not steady.
   task automatic send_item(logic kind, logic start, logic [47:0] pix, logic [10:0] row);
      while (!source_steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_frame_start <= start;
      {req_on_red, req_on_green, req_on_blue,
       req_off_red, req_off_green, req_off_blue} <= pix;
      req_query_row <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_pixel(logic start, logic [47:0] pix);
      send_item(KIND_PIXEL, start, pix, 11'($urandom));
   endtask

   // Rows at or beyond the height, or ones already written, are legal.
   task automatic send_readout();
      logic [10:0] row;
      case ($urandom_range(3))
         0: row = 11'($urandom_range(2047, frame_h));
         default: row = (rows_written == 0) ? 11'(frame_h) :
                        11'($urandom_range(rows_written - 1));
      endcase
      if (row < frame_h && row >= rows_written) row = 11'(frame_h);
      send_item(KIND_READOUT, 1'($urandom_range(1)), {$urandom, 16'($urandom)}, row);
   endtask

   // A pixel pair biased toward a bright red laser spot now and then.
   function automatic logic [47:0] random_pixel();
      logic [47:0] p;
      p = {$urandom, 16'($urandom)};
      if ($urandom_range(3) == 0) p[47:40] = 8'($urandom_range(255, 160));
      return p;
   endfunction

   // Stream a frame of random pixels with readouts mixed in, then extra pixels and four readouts.
   task automatic send_frame(int extra);
      for (int r = 0; r < frame_h; r++) begin
         for (int c = 0; c < frame_w; c++) begin
            send_pixel(r == 0 && c == 0, random_pixel());
            if ($urandom_range(9) == 0) send_readout();
         end
         rows_written = (r + 1 > rows_written) ? r + 1 : rows_written;
      end
      for (int i = 0; i < extra; i++) send_pixel(1'b0, random_pixel());
      for (int i = 0; i < 4; i++) send_readout();
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      // Pixels still in the queue leave it during this wait.
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [23:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Readouts may only touch rows whose store entry has been written, so a
   // new geometry resets the written-row tally for a fresh frame.
   task automatic set_geometry(logic [11:0] w, logic [11:0] h, logic [23:0] a,
                               logic [23:0] b, logic [23:0] c, logic [23:0] d);
      write_reg(CSR_FRAME_WIDTH, 24'(w));
      write_reg(CSR_FRAME_HEIGHT, 24'(h));
      write_reg(CSR_QUAD_A, a);
      write_reg(CSR_QUAD_B, b);
      write_reg(CSR_QUAD_C, c);
      write_reg(CSR_QUAD_D, d);
      frame_w = (w == 0) ? 1 : w;
      frame_h = (h == 0) ? 1 : h;
      rows_written = 0;
   endtask

   function automatic logic [23:0] random_vertex(int xmax, int ymax);
      return {12'($urandom_range(xmax)), 12'($urandom_range(ymax))};
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on a tiny 4x3 frame: byte extremes, a tie for the peak
      // (first column wins), frame start, extra pixels beyond the frame,
      // readouts inside and outside it. A zero width and height act as 1.
      set_geometry(12'd4, 12'd3, {12'd0, 12'd0}, {12'd0, 12'd2},
                   {12'd3, 12'd2}, {12'd3, 12'd0});
      source_steady = 1'b1;
      send_pixel(1'b1, {8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff});
      send_pixel(1'b0, {8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00});
      send_pixel(1'b0, {8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      send_pixel(1'b0, {8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      send_pixel(1'b0, {8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff});
      send_pixel(1'b0, {8'h40, 8'h00, 8'h00, 8'h10, 8'h20, 8'h30});
      send_pixel(1'b0, {8'h40, 8'h00, 8'h00, 8'h10, 8'h20, 8'h30});
      send_pixel(1'b0, {8'h10, 8'h20, 8'h20, 8'h00, 8'h00, 8'h00});
      for (int i = 0; i < 4; i++) send_pixel(1'b0, 48'h08_00_00_01_02_03);
      send_pixel(1'b0, 48'hff_00_00_00_00_00);
      rows_written = 3;
      for (int q = 0; q < 4; q++) send_item(KIND_READOUT, 1'b1, '1, 11'(q));
      send_item(KIND_READOUT, 1'b0, '0, 11'h7ff);
      source_steady = 1'b0;
      wait_idle();
      set_geometry(12'd0, 12'd0, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
      send_pixel(1'b1, 48'hff_00_00_00_00_00);
      rows_written = 1;
      send_readout();
      send_readout();
      wait_idle();

      // Random phases with several geometries, small frames mostly.
      for (int phase = 0; phase < 8; phase++) begin
         int w, h;
         w = $urandom_range(12, 1);
         h = $urandom_range(10, 1);
         if (phase == 0) begin
            set_geometry(12'd64, 12'd3, '0, {12'd0, 12'd2}, {12'd2047, 12'd2},
                         {12'd2047, 12'd0});
         end else if (phase == 1) begin
            set_geometry(12'hfff, 12'hfff, '0, '0, '0, '0);
            frame_w = 2048; frame_h = 2048;
            send_pixel(1'b1, random_pixel());
            for (int i = 0; i < 20; i++) send_readout();
            wait_idle();
            continue;
         end else begin
            set_geometry(12'(w), 12'(h), random_vertex(w, h), random_vertex(w, h),
                         random_vertex(w, h), random_vertex(w, h));
         end
         source_steady = (phase == 3);
         sink_steady = (phase == 3);
         for (int f = 0; f < 3; f++) send_frame($urandom_range(3));
         if (phase == 4) begin
            fork
               long_hold_off();
               for (int i = 0; i < 30; i++) send_readout();
            join
         end
         source_steady = 1'b0;
         sink_steady = 1'b0;
         wait_idle();
      end
      set_geometry(12'd640, 12'd480, QUAD_A_RST, QUAD_B_RST, QUAD_C_RST, QUAD_D_RST);
      wait_idle();

      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/llrpd_pkg.sv
src/llrpd_front.sv
src/llrpd_queue.sv
src/llrpd_back.sv
src/laser_line_row_peak_detector.sv
src/llrpd_checker.sv
sim/laser_line_row_peak_detector_checker.sv
sim/tb_laser_line_row_peak_detector.sv
